// ----- design/rmc_pkg.sv -----
`default_nettype none
package rmc_pkg;

    typedef enum logic [0:0] {
        PH_HEADER = 1'b0,
        PH_SKIP   = 1'b1
    } t_phase;

    localparam logic [1:0] EV_VIDEO = 2'd0;
    localparam logic [1:0] EV_AUDIO = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic CFG_STEP = 1'b0;
    localparam logic CFG_BASE = 1'b1;

    localparam logic [31:0] ID_LIST   = 32'h5453_494C;
    localparam logic [7:0]  CH_D      = 8'h64;
    localparam logic [7:0]  CH_C      = 8'h63;
    localparam logic [7:0]  CH_B      = 8'h62;
    localparam logic [7:0]  CH_W      = 8'h77;
    localparam logic [23:0] FRAME_MAX = 24'hFF_FFFF;

    localparam int TDATA_W = 144;
    localparam int TUSER_W = 3;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] stream_id;
        logic [31:0] payload_size;
        logic [31:0] payload_offset;
        logic [23:0] frame_number;
        logic        checkpoint_valid;
        logic [4:0]  checkpoint_slot;
        logic [31:0] checkpoint_offset;
    } t_result;

endpackage
`default_nettype wire

// ----- design/rmc_parser.sv -----
`default_nettype none
module rmc_parser #(
    parameter int CHECKPOINT_COUNT = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_strobe,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    output rmc_pkg::t_result     o_res,
    output logic                 o_res_valid
);
    import rmc_pkg::*;

    localparam int SW = $clog2(CHECKPOINT_COUNT + 1);
    localparam logic [SW-1:0] SLOT_LIMIT = SW'(CHECKPOINT_COUNT);

    t_phase          r_phase, n_phase;
    logic [2:0]      r_hcnt, n_hcnt;
    logic [31:0]     r_id, n_id;
    logic [23:0]     r_size, n_size;
    logic [32:0]     r_skip, n_skip;
    logic [31:0]     r_pos, n_pos;
    logic [31:0]     r_after, n_after;
    logic [23:0]     r_frame, n_frame;
    logic [15:0]     r_cdown, n_cdown;
    logic [SW-1:0]   r_slot, n_slot;
    logic [15:0]     r_step;
    logic [31:0]     r_base;

    logic [31:0]     sz;
    logic            pad;
    logic [31:0]     coff;
    logic [SW+4:0]   slot_ext;

    assign sz       = {i_byte, r_size};
    assign pad      = sz[0];
    assign coff     = r_after + sz + {31'd0, pad};
    assign slot_ext = {5'd0, r_slot};

    always_comb begin
        n_phase     = r_phase;
        n_hcnt      = r_hcnt;
        n_id        = r_id;
        n_size      = r_size;
        n_skip      = r_skip;
        n_pos       = r_pos + 32'd1;
        n_after     = r_after + 32'd1;
        n_frame     = r_frame;
        n_cdown     = r_cdown;
        n_slot      = r_slot;
        o_res       = '0;
        o_res_valid = 1'b0;

        if (r_phase == PH_SKIP) begin
            if (r_skip != 33'd0) begin
                n_skip = r_skip - 33'd1;
            end
            if (n_skip == 33'd0) begin
                n_phase = PH_HEADER;
            end
        end else begin
            if (!r_hcnt[2]) begin
                n_id[8*r_hcnt[1:0] +: 8] = i_byte;
            end else if (r_hcnt != 3'd7) begin
                n_size[8*r_hcnt[1:0] +: 8] = i_byte;
            end
            n_hcnt = r_hcnt + 3'd1;
        end

        if (i_last) begin
            // The end event wins over a header completed by the same byte.
            o_res_valid          = 1'b1;
            o_res.event_kind     = EV_END;
            o_res.payload_offset = r_after;
            o_res.frame_number   = r_frame;
            n_phase = PH_HEADER;
            n_hcnt  = 3'd0;
            n_skip  = 33'd0;
            n_pos   = 32'd0;
            n_after = r_base + 32'd1;
            n_frame = 24'd0;
            n_cdown = r_step;
            n_slot  = SW'(1);
        end else if (r_phase == PH_HEADER && r_hcnt == 3'd7) begin
            if (r_id == ID_LIST) begin
                n_skip  = 33'd4;
                n_phase = PH_SKIP;
            end else begin
                n_skip  = {1'b0, sz} + {32'd0, pad};
                n_phase = (sz != 32'd0) ? PH_SKIP : PH_HEADER;
                o_res.stream_id      = r_id[15:0];
                o_res.payload_size   = sz;
                o_res.payload_offset = r_after;
                o_res.frame_number   = r_frame;
                if (sz != 32'd0 && r_id[23:16] == CH_D
                        && (r_id[31:24] == CH_C || r_id[31:24] == CH_B)) begin
                    o_res_valid      = 1'b1;
                    o_res.event_kind = EV_VIDEO;
                    if (r_frame != FRAME_MAX) begin
                        n_frame = r_frame + 24'd1;
                        o_res.frame_number = n_frame;
                        if (r_step != 16'd0) begin
                            if (r_cdown <= 16'd1) begin
                                n_cdown = r_step;
                                if (r_slot < SLOT_LIMIT) begin
                                    o_res.checkpoint_valid  = 1'b1;
                                    o_res.checkpoint_slot   = slot_ext[4:0];
                                    o_res.checkpoint_offset = coff;
                                    n_slot = r_slot + SW'(1);
                                end
                            end else begin
                                n_cdown = r_cdown - 16'd1;
                            end
                        end
                    end
                end else if (sz != 32'd0 && r_id[23:16] == CH_W
                        && r_id[31:24] == CH_B) begin
                    o_res_valid      = 1'b1;
                    o_res.event_kind = EV_AUDIO;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= 3'd0;
            r_skip  <= 33'd0;
            r_pos   <= 32'd0;
            r_after <= 32'd1;
            r_frame <= 24'd0;
            r_cdown <= 16'd1;
            r_slot  <= SW'(1);
            r_step  <= 16'd1;
            r_base  <= 32'd0;
        end else if (i_strobe) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_skip  <= n_skip;
            r_pos   <= n_pos;
            r_after <= n_after;
            r_frame <= n_frame;
            r_cdown <= n_cdown;
            r_slot  <= n_slot;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_STEP) begin
                r_step  <= i_cfg_data[15:0];
                r_cdown <= i_cfg_data[15:0];
            end else begin
                r_base  <= i_cfg_data;
                r_after <= i_cfg_data + r_pos + 32'd1;
            end
        end
    end

    // Header bytes need no reset; every field is rewritten before it is used.
    always_ff @(posedge i_clk) begin
        if (i_strobe) begin
            r_id   <= n_id;
            r_size <= n_size;
        end
    end

endmodule
`default_nettype wire

// ----- design/riff_movi_chunk_classifier.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// s_axis    in         i_s_tvalid/o_s_tready  tdata: data_byte; tlast: last_byte
// m_axis    out        o_m_tvalid/i_m_tready  tdata: chunk event; tuser: kind, checkpoint
// cfg       in         i_cfg_we               i_cfg_idx, i_cfg_data (no read-back)
//
// One byte is taken every cycle while the output is not stalled; an item goes from the
// input register through the parser logic into the result register, and o_m_tvalid
// rises when the parser advances the item into the result register. A result held in
// the result register stalls the parser, and the input register is free again in the
// same cycle that the parser advances. Reset is synchronous and needs no clearing pass.
module riff_movi_chunk_classifier #(
    parameter int CHECKPOINT_COUNT = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [31:0]                 i_cfg_data,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] data_byte
    input  wire logic [7:0]                  i_s_tdata,
    input  wire logic                        i_s_tlast,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [15:0] stream_id, [47:16] payload_size, [79:48] payload_offset,
    // [103:80] frame_number, [108:104] checkpoint_slot, [140:109] checkpoint_offset
    output logic [rmc_pkg::TDATA_W-1:0]      o_m_tdata,
    // [1:0] event_kind, [2] checkpoint_valid
    output logic [rmc_pkg::TUSER_W-1:0]      o_m_tuser
);
    import rmc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        advance;
    t_result     res;
    logic        res_valid;
    logic        r_out_valid;
    t_result     r_out;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    rmc_parser #(
        .CHECKPOINT_COUNT(CHECKPOINT_COUNT)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_strobe   (advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_res      (res),
        .o_res_valid(res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out.checkpoint_offset, r_out.checkpoint_slot,
                         r_out.frame_number, r_out.payload_offset,
                         r_out.payload_size, r_out.stream_id};
    assign o_m_tuser  = {r_out.checkpoint_valid, r_out.event_kind};

endmodule
`default_nettype wire

// ----- design/rmc_checker.sv -----
`default_nettype none
module rmc_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_m_tvalid,
    input wire logic                     i_m_tready,
    input wire logic [rmc_pkg::TDATA_W-1:0] o_m_tdata,
    input wire logic [rmc_pkg::TUSER_W-1:0] o_m_tuser
);
    import rmc_pkg::*;

    // An end event carries no stream id, no size and no checkpoint.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] == EV_END
        |-> o_m_tdata[47:0] == 48'd0 && !o_m_tuser[2] && o_m_tdata[140:104] == 37'd0)
        else $error("end event carries chunk fields");

    // Only video chunks record checkpoints.
    a_cp_video: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tuser[1:0] == EV_VIDEO)
        else $error("checkpoint on a non-video event");

    // A chunk event always reports a nonzero size.
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] == EV_VIDEO || o_m_tuser[1:0] == EV_AUDIO)
        |-> o_m_tdata[47:16] != 32'd0)
        else $error("chunk event with zero size");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind riff_movi_chunk_classifier rmc_checker u_rmc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
`default_nettype wire
